// File: src/mrds_pkg.sv
package mrds_pkg;

  localparam int PIXEL_COUNT_BITS_DEF   = 22;
  localparam int ROOT_FRACTION_BITS_DEF = 8;

  // integer bits of the root of 255*255*3
  localparam int ROOT_INT_BITS = 9;
  localparam int D2_W          = 18;
  localparam longint unsigned MAX_SQUARED_DISTANCE = 64'd195075;

  localparam int SCORE_W       = 17;
  localparam int SCORE_STEPS   = 17;
  localparam int COUNT_FIELD_W = 23;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DARK_LEVEL = 1'b0;
  localparam logic [7:0] DARK_LEVEL_RESET = 8'd2;

  typedef struct packed {
    logic [7:0] mask_red;
    logic [7:0] mask_green;
    logic [7:0] mask_blue;
    logic [7:0] image_red;
    logic [7:0] image_green;
    logic [7:0] image_blue;
    logic       last_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [SCORE_W-1:0]       score;
    logic [COUNT_FIELD_W-1:0] compared_count;
    logic [COUNT_FIELD_W-1:0] different_count;
    logic [COUNT_FIELD_W-1:0] ignored_count;
    logic                     none_compared;
  } out_beat_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic            dark;
    logic            last;
    logic [D2_W-1:0] d2;
  } q_entry_t;

  // floor root of the largest squared distance with frac fraction bits
  function automatic longint unsigned max_root(input int frac);
    longint unsigned v;
    longint unsigned root;
    longint unsigned t;
    v = MAX_SQUARED_DISTANCE << (2 * frac);
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      t = root | (64'd1 << i);
      if (t * t <= v) begin
        root = t;
      end
    end
    return root;
  endfunction

endpackage

// File: src/mrds_front.sv
module mrds_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  mrds_pkg::in_beat_t  in_data,
  input  logic [7:0]          dark_level,
  input  logic                q_full,
  output logic                in_stall,
  output logic                q_push,
  output mrds_pkg::q_entry_t  q_wdata
);

  logic [7:0]  dr;
  logic [7:0]  dg;
  logic [7:0]  db;
  logic [15:0] sr;
  logic [15:0] sg;
  logic [15:0] sb;
  logic        dark;

  assign dr = (in_data.mask_red > in_data.image_red) ?
              in_data.mask_red - in_data.image_red : in_data.image_red - in_data.mask_red;
  assign dg = (in_data.mask_green > in_data.image_green) ?
              in_data.mask_green - in_data.image_green :
              in_data.image_green - in_data.mask_green;
  assign db = (in_data.mask_blue > in_data.image_blue) ?
              in_data.mask_blue - in_data.image_blue : in_data.image_blue - in_data.mask_blue;

  assign sr = 16'(dr) * 16'(dr);
  assign sg = 16'(dg) * 16'(dg);
  assign sb = 16'(db) * 16'(db);

  assign dark = (in_data.mask_red < dark_level) && (in_data.mask_green < dark_level) &&
                (in_data.mask_blue < dark_level);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata      = '0;
    q_wdata.dark = dark;
    q_wdata.last = in_data.last_pixel;
    q_wdata.d2   = mrds_pkg::D2_W'(18'(sr) + 18'(sg) + 18'(sb));
  end

endmodule

// File: src/mrds_fifo.sv
module mrds_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mrds_pkg::q_entry_t wdata,
  input  logic               pop,
  output mrds_pkg::q_entry_t rdata,
  output logic               full,
  output logic               empty
);

  mrds_pkg::q_entry_t            slot_r [mrds_pkg::QUEUE_DEPTH];
  logic [mrds_pkg::QPTR_W:0]     wptr_r;
  logic [mrds_pkg::QPTR_W:0]     wptr_nxt;
  logic [mrds_pkg::QPTR_W:0]     rptr_r;
  logic [mrds_pkg::QPTR_W:0]     rptr_nxt;

  assign empty = (wptr_r == rptr_r);
  assign full  = (wptr_r[mrds_pkg::QPTR_W] != rptr_r[mrds_pkg::QPTR_W]) &&
                 (wptr_r[mrds_pkg::QPTR_W-1:0] == rptr_r[mrds_pkg::QPTR_W-1:0]);
  assign rdata = slot_r[rptr_r[mrds_pkg::QPTR_W-1:0]];

  assign wptr_nxt = (push && !full) ? wptr_r + 1'b1 : wptr_r;
  assign rptr_nxt = (pop && !empty) ? rptr_r + 1'b1 : rptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r[mrds_pkg::QPTR_W-1:0]] <= wdata;
    end
  end

endmodule

// File: src/mrds_back.sv
module mrds_back #(
  parameter int PIXEL_COUNT_BITS   = mrds_pkg::PIXEL_COUNT_BITS_DEF,
  parameter int ROOT_FRACTION_BITS = mrds_pkg::ROOT_FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  mrds_pkg::q_entry_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mrds_pkg::out_beat_t out_data
);

  localparam int CNT_W   = PIXEL_COUNT_BITS + 1;
  localparam int ROOT_W  = mrds_pkg::ROOT_INT_BITS + ROOT_FRACTION_BITS;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int DEN_W   = CNT_W + ROOT_W;
  localparam int STEP_MAX = (ROOT_W > mrds_pkg::SCORE_STEPS) ? ROOT_W : mrds_pkg::SCORE_STEPS;
  localparam int STEP_W  = $clog2(STEP_MAX);
  localparam logic [ROOT_W-1:0] MAX_ROOT =
    ROOT_W'(mrds_pkg::max_root(ROOT_FRACTION_BITS));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROOT  = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]        state_r,   state_nxt;
  logic [STEP_W-1:0] step_r,    step_nxt;
  logic              last_r,    last_nxt;
  logic [DEN_W-1:0]  sum_r,     sum_nxt;
  logic [CNT_W-1:0]  cmp_r,     cmp_nxt;
  logic [CNT_W-1:0]  diff_r,    diff_nxt;
  logic [CNT_W-1:0]  ign_r,     ign_nxt;
  logic [RAD_W-1:0]  rad_r,     rad_nxt;
  logic [REM_W-1:0]  rem_r,     rem_nxt;
  logic [ROOT_W-1:0] root_r,    root_nxt;
  logic [DEN_W-1:0]  den_r,     den_nxt;
  logic [DEN_W-1:0]  mc_r,      mc_nxt;
  logic [ROOT_W-1:0] mb_r,      mb_nxt;
  logic [DEN_W:0]    rd_r,      rd_nxt;
  logic [mrds_pkg::SCORE_W-1:0] q_r, q_nxt;
  logic              out_valid_r, out_valid_nxt;
  mrds_pkg::out_beat_t out_data_r, out_data_nxt;

  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic [DEN_W:0]    rsh;
  logic [DEN_W:0]    den_x;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  assign rem_t = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = (REM_W+2)'({root_r, 2'b01});
  assign rsh   = (step_r == STEP_W'(mrds_pkg::SCORE_STEPS - 1)) ? rd_r : {rd_r[DEN_W-1:0], 1'b0};
  assign den_x = {1'b0, den_r};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    cmp_nxt       = cmp_r;
    diff_nxt      = diff_r;
    ign_nxt       = ign_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    den_nxt       = den_r;
    mc_nxt        = mc_r;
    mb_nxt        = mb_r;
    rd_nxt        = rd_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          last_nxt = q_rdata.last;
          state_nxt = q_rdata.last ? ST_FIN : ST_IDLE;
          if (q_rdata.dark) begin
            if (!ign_r[CNT_W-1]) begin
              ign_nxt = ign_r + 1'b1;
            end
          end else if (!cmp_r[CNT_W-1]) begin
            cmp_nxt = cmp_r + 1'b1;
            if (q_rdata.d2 != '0) begin
              diff_nxt  = diff_r + 1'b1;
              rad_nxt   = {q_rdata.d2, (2 * ROOT_FRACTION_BITS)'(0)};
              rem_nxt   = '0;
              root_nxt  = '0;
              step_nxt  = STEP_W'(ROOT_W - 1);
              state_nxt = ST_ROOT;
            end
          end
        end
      end
      ST_ROOT: begin
        // one root bit per cycle, two radicand bits brought down
        rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem_nxt  = REM_W'(rem_t - trial);
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(rem_t);
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          sum_nxt   = sum_r + DEN_W'(root_nxt);
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (cmp_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          den_nxt   = '0;
          mc_nxt    = DEN_W'(cmp_r);
          mb_nxt    = MAX_ROOT;
          step_nxt  = STEP_W'(ROOT_W - 1);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // shift-add of count by the constant maximum root
        if (mb_r[0]) begin
          den_nxt = den_r + mc_r;
        end
        mc_nxt   = {mc_r[DEN_W-2:0], 1'b0};
        mb_nxt   = mb_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        rd_nxt    = (sum_r > den_r) ? den_x : {1'b0, sum_r};
        q_nxt     = '0;
        step_nxt  = STEP_W'(mrds_pkg::SCORE_STEPS - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rsh >= den_x) begin
          rd_nxt = rsh - den_x;
          q_nxt  = {q_r[mrds_pkg::SCORE_W-2:0], 1'b1};
        end else begin
          rd_nxt = rsh;
          q_nxt  = {q_r[mrds_pkg::SCORE_W-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.none_compared   = (cmp_r == '0);
          out_data_nxt.score           = (cmp_r == '0) ? '0 : q_r;
          out_data_nxt.compared_count  = mrds_pkg::COUNT_FIELD_W'(cmp_r);
          out_data_nxt.different_count = mrds_pkg::COUNT_FIELD_W'(diff_r);
          out_data_nxt.ignored_count   = mrds_pkg::COUNT_FIELD_W'(ign_r);
          sum_nxt   = '0;
          cmp_nxt   = '0;
          diff_nxt  = '0;
          ign_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      last_r      <= 1'b0;
      sum_r       <= '0;
      cmp_r       <= '0;
      diff_r      <= '0;
      ign_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      sum_r       <= sum_nxt;
      cmp_r       <= cmp_nxt;
      diff_r      <= diff_nxt;
      ign_r       <= ign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    den_r      <= den_nxt;
    mc_r       <= mc_nxt;
    mb_r       <= mb_nxt;
    rd_r       <= rd_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: src/mask_rgb_distance_score_top.sv
// Masked mean RGB distance score.
// in_*  : one beat per pixel pair (mask pixel, image pixel, last_pixel flag).
//         A beat moves when in_valid is high and in_stall is low.
// out_* : one beat per frame, after the beat flagged last_pixel: score in 1.16
//         format, the three pixel counts and none_compared (score 0 then).
// psel/penable/pwrite/paddr/pwdata/prdata/pready: register port, pready tied
//         high. dark_level at byte address 0, reset value 2.
// Flow: a front stage classifies each pixel (dark test, squared distance)
// into a 4-entry queue, so in_stall only rises when the queue fills. The back
// stage retires a dark or zero-distance pixel in its idle state; a pixel with a
// nonzero distance also runs the bit-serial root unit, which sets the pace, and
// no new pixel is popped until its root is done. Frame end runs ST_FIN, the
// shift-add multiply by the max root (ST_MUL), ST_CLAMP, the divider (ST_DIV)
// and ST_EMIT; when nothing was compared it goes from ST_FIN straight to ST_EMIT.
// out_valid comes from a register that ST_EMIT sets.
// The result sits in an output register; while out_stall holds it, the back
// stage keeps working on the next frame and only waits at the next frame end.
// Reset (rst_n low, synchronous) clears all totals, the queue and out_valid.
module mask_rgb_distance_score_top #(
  parameter int PIXEL_COUNT_BITS   = mrds_pkg::PIXEL_COUNT_BITS_DEF,
  parameter int ROOT_FRACTION_BITS = mrds_pkg::ROOT_FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mrds_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mrds_pkg::out_beat_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mrds_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mrds_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mrds_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic [7:0]          dark_level_r;
  logic [7:0]          dark_level_nxt;
  logic                reg_write;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  mrds_pkg::q_entry_t  q_wdata;
  mrds_pkg::q_entry_t  q_rdata;

  // register port: word index sits at paddr[2]
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;
  assign dark_level_nxt = (reg_write && (paddr[2] == mrds_pkg::REG_DARK_LEVEL)) ?
                          pwdata[7:0] : dark_level_r;
  assign prdata = (paddr[2] == mrds_pkg::REG_DARK_LEVEL) ?
                  mrds_pkg::CFG_DATA_W'(dark_level_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_level_r <= mrds_pkg::DARK_LEVEL_RESET;
    end else begin
      dark_level_r <= dark_level_nxt;
    end
  end

  // front: dark test and squared distance, straight into the queue
  mrds_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .dark_level (dark_level_r),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  mrds_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: totals, serial root, frame-end multiply and divide, output register
  mrds_back #(
    .PIXEL_COUNT_BITS   (PIXEL_COUNT_BITS),
    .ROOT_FRACTION_BITS (ROOT_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
